FILE: src/sspd_pkg.sv
// ----------------------------------------------------------------------------
// sspd_pkg
// Shared types, codes and the seven-segment table of the display driver.
// ----------------------------------------------------------------------------
`default_nettype none

package sspd_pkg;

    localparam int C_HEARTBEAT_TICKS = 500;
    localparam int C_DUTY_STEPS      = 5;
    localparam int C_NUMBER_W        = 16;
    localparam int C_BRIGHT_W        = 16;
    localparam int C_PATTERN_W       = 8;
    localparam int C_IN_TDATA_W      = 40;
    localparam int C_OUT_TDATA_W     = 16;

    typedef enum logic {
        ACT_TICK   = 1'b0,
        ACT_UPDATE = 1'b1
    } t_action;

    typedef enum logic {
        CFG_ON_LEVEL  = 1'b0,
        CFG_OFF_LEVEL = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_action                 action;
        logic [C_NUMBER_W-1:0]   shown_number;
        logic [C_BRIGHT_W-1:0]   brightness;
        logic                    coil_bit;
    } t_item;

    typedef struct packed {
        logic                    heartbeat_led;
        logic                    tens_digit_on;
        logic [C_PATTERN_W-1:0]  segment_pattern;
        logic                    enable_pin;
    } t_result;

    function automatic logic [C_PATTERN_W-1:0] seg_code(input logic [3:0] digit);
        logic [C_PATTERN_W-1:0] code;
        unique case (digit)
            4'd0:    code = 8'h7E;
            4'd1:    code = 8'h42;
            4'd2:    code = 8'hEC;
            4'd3:    code = 8'hE6;
            4'd4:    code = 8'hD2;
            4'd5:    code = 8'hB6;
            4'd6:    code = 8'h9E;
            4'd7:    code = 8'h62;
            4'd8:    code = 8'hFE;
            4'd9:    code = 8'hF2;
            default: code = '0;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

FILE: src/sspd_core.sv
// ----------------------------------------------------------------------------
// sspd_core
// Display state: PWM duty counter, heartbeat divider, segment and tens
// registers, enable levels. Gives the outputs after the word in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module sspd_core
    import sspd_pkg::*;
#(
    parameter int HEARTBEAT_TICKS = C_HEARTBEAT_TICKS,
    parameter int DUTY_STEPS      = C_DUTY_STEPS
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_cfg_we,
    input  wire logic    i_cfg_idx,
    input  wire logic    i_cfg_data,
    input  wire logic    i_adv,
    input  wire t_item   i_item,
    output t_result      o_result
);

    localparam int BW = $clog2(DUTY_STEPS + 1);
    localparam int DW = BW + 1;
    localparam int TW = $clog2(HEARTBEAT_TICKS);

    localparam logic signed [DW-1:0] DUTY_S    = DW'(DUTY_STEPS);
    localparam logic signed [DW-1:0] DUTY_ONE  = DW'(1);
    localparam logic signed [DW-1:0] DUTY_ZERO = '0;
    localparam logic [TW-1:0]        TICK_LAST = TW'(HEARTBEAT_TICKS - 1);

    logic                    r_on,      n_on;
    logic                    r_off,     n_off;
    logic                    r_enable,  n_enable;
    logic [C_PATTERN_W-1:0]  r_pattern, n_pattern;
    logic                    r_tens,    n_tens;
    logic                    r_hb,      n_hb;
    logic [TW-1:0]           r_tick,    n_tick;
    logic signed [DW-1:0]    r_duty,    n_duty;
    logic [BW-1:0]           r_bright,  n_bright;

    logic signed [DW-1:0]    w_bright_s;
    logic signed [DW-1:0]    w_duty_base;
    logic [4:0]              w_sub;

    assign w_bright_s  = signed'({1'b0, r_bright});
    assign w_duty_base = (r_duty >= w_bright_s) ? (w_bright_s - DUTY_S) : r_duty;
    assign w_sub       = i_item.shown_number[4:0] - 5'd10;

    always_comb begin
        n_on      = r_on;
        n_off     = r_off;
        n_enable  = r_enable;
        n_pattern = r_pattern;
        n_tens    = r_tens;
        n_hb      = r_hb;
        n_tick    = r_tick;
        n_duty    = r_duty;
        n_bright  = r_bright;

        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ON_LEVEL:  n_on  = i_cfg_data;
                CFG_OFF_LEVEL: n_off = i_cfg_data;
                default:       n_on  = r_on;
            endcase
        end

        unique case (i_item.action)
            ACT_TICK: begin
                n_enable = (r_duty <= DUTY_ZERO) ? r_off : ~(r_on ^ i_item.coil_bit);
                n_duty   = w_duty_base + DUTY_ONE;
                if (r_tick == TICK_LAST) begin
                    n_tick = '0;
                    n_hb   = ~r_hb;
                end else begin
                    n_tick = r_tick + TW'(1);
                end
            end
            ACT_UPDATE: begin
                if (i_item.shown_number <= C_NUMBER_W'(9)) begin
                    n_pattern = seg_code(i_item.shown_number[3:0]);
                    n_tens    = 1'b0;
                end else if (i_item.shown_number < C_NUMBER_W'(20)) begin
                    n_pattern = seg_code(w_sub[3:0]);
                    n_tens    = 1'b1;
                end
                if (i_item.brightness <= C_BRIGHT_W'(DUTY_STEPS)) begin
                    n_bright = i_item.brightness[BW-1:0];
                end
            end
            default: n_duty = r_duty;
        endcase
    end

    // config regs take writes at any time; item state moves on advance only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on      <= 1'b1;
            r_off     <= 1'b0;
            r_enable  <= 1'b0;
            r_pattern <= '0;
            r_tens    <= 1'b0;
            r_hb      <= 1'b1;
            r_tick    <= '0;
            r_duty    <= DUTY_ONE;
            r_bright  <= BW'(DUTY_STEPS);
        end else begin
            r_on  <= n_on;
            r_off <= n_off;
            if (i_adv) begin
                r_enable  <= n_enable;
                r_pattern <= n_pattern;
                r_tens    <= n_tens;
                r_hb      <= n_hb;
                r_tick    <= n_tick;
                r_duty    <= n_duty;
                r_bright  <= n_bright;
            end
        end
    end

    assign o_result.enable_pin      = n_enable;
    assign o_result.segment_pattern = n_pattern;
    assign o_result.tens_digit_on   = n_tens;
    assign o_result.heartbeat_led   = n_hb;

endmodule

`default_nettype wire

FILE: src/seven_segment_pwm_display_driver.sv
// Path: an accepted input word passes the input register, then the output register.
// Throughput: one word per cycle while i_m_tready is high; an input register
// and an output register decouple the sides: one word enters while a result waits.
// Reset: synchronous, active low; clears both stages and loads state defaults.
// ----------------------------------------------------------------------------
// seven_segment_pwm_display_driver
// Seven-segment driver with PWM dimming of the enable pin and a heartbeat LED.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_pwm_display_driver
    import sspd_pkg::*;
#(
    parameter int HEARTBEAT_TICKS = C_HEARTBEAT_TICKS,
    parameter int DUTY_STEPS      = C_DUTY_STEPS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_tvalid,
    output logic                           o_s_tready,
    // [15:0] shown_number, [31:16] brightness, [32] coil_bit, [39:33] zero
    input  wire logic [C_IN_TDATA_W-1:0]   i_s_tdata,
    // [0] action
    input  wire logic                      i_s_tuser,
    output logic                           o_m_tvalid,
    input  wire logic                      i_m_tready,
    // [0] enable_pin, [8:1] segment_pattern, [9] tens_digit_on,
    // [10] heartbeat_led, [15:11] zero
    output logic [C_OUT_TDATA_W-1:0]       o_m_tdata,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_idx,
    input  wire logic                      i_cfg_data
);

    logic    r_in_v;
    t_item   r_in;
    logic    r_out_v;
    t_result r_out;
    logic    w_accept;
    logic    w_adv;
    t_result w_result;

    assign o_s_tready = !r_in_v || !r_out_v || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_adv      = r_in_v && (!r_out_v || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_v <= 1'b1;
            end else if (w_adv) begin
                r_in_v <= 1'b0;
            end
            if (w_adv) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.action       <= t_action'(i_s_tuser);
            r_in.shown_number <= i_s_tdata[15:0];
            r_in.brightness   <= i_s_tdata[31:16];
            r_in.coil_bit     <= i_s_tdata[32];
        end
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    sspd_core #(
        .HEARTBEAT_TICKS (HEARTBEAT_TICKS),
        .DUTY_STEPS      (DUTY_STEPS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_adv      (w_adv),
        .i_item     (r_in),
        .o_result   (w_result)
    );

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {5'b0, r_out.heartbeat_led, r_out.tens_digit_on,
                         r_out.segment_pattern, r_out.enable_pin};

endmodule

`default_nettype wire

FILE: src/sspd_checker.sv
// ----------------------------------------------------------------------------
// sspd_checker
// Port-level checks of the display driver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sspd_checker
    import sspd_pkg::*;
(
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_s_tvalid,
    input wire logic                      o_s_tready,
    input wire logic                      o_m_tvalid,
    input wire logic                      i_m_tready,
    input wire logic [C_OUT_TDATA_W-1:0]  o_m_tdata
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled without output backpressure");

    a_word_arrives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |-> ##2 o_m_tvalid)
        else $error("accepted word produced no output");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled output word changed");

endmodule

bind seven_segment_pwm_display_driver sspd_checker u_sspd_checker (.*);

`default_nettype wire
